/* rtl/vsd_pkg.sv */
// Package for the varint stream decoder: field widths, byte limits and stream widths.
// No dependencies; the top level refers to it by scoped names.
`default_nettype none

package vsd_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PAYLOAD_W = 7;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned COUNT_W   = 4;

    // Shift position counter: at most 7 * 9 = 63
    localparam int unsigned SHIFT_W   = 7;

    // Byte limits per width mode (35 and 70 payload bits)
    localparam logic [COUNT_W-1:0] LIMIT_SHORT = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] LIMIT_LONG  = COUNT_W'(10);

    // Stream widths: tdata padded up to whole bytes
    localparam int unsigned IN_TDATA_W  = BYTE_W;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_FIELD_W = VALUE_W + COUNT_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
    localparam int unsigned OUT_TUSER_W = 1;

endpackage

`default_nettype wire

/* rtl/varint_stream_decoder_unit.sv */
// Channel  | Direction | Payload (low bit first)                        | Handshake
// s_axis   | in        | tdata: data_byte; tuser: long_mode, signed_mode | tvalid/tready
// m_axis   | out       | tdata: value, byte_count, zero pad; tuser: overlong | tvalid/tready
//
// One byte is taken per cycle unless stalled; a finished value appears on m_axis the cycle
// after its last byte is taken. The accumulator update and the zigzag decode sit between
// the state registers and the result register, so the rate is one byte per clock unless
// stalled. s_axis_tready is low only while a result is held and m_axis_tready is low.
// rst_n clears the decoder state and drops m_axis_tvalid.
//
// Top level of the LEB128 varint decoder with zigzag support.
// Depends on vsd_pkg.
`default_nettype none

module varint_stream_decoder_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // [7:0] data_byte
    input  wire logic [vsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] long_mode, [1] signed_mode
    input  wire logic [vsd_pkg::IN_TUSER_W-1:0]   s_axis_tuser,

    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [63:0] value, [67:64] byte_count, [71:68] zero
    output      logic [vsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] overlong
    output      logic [vsd_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

    localparam int unsigned VW = vsd_pkg::VALUE_W;
    localparam int unsigned HW = vsd_pkg::HALF_W;
    localparam int unsigned CW = vsd_pkg::COUNT_W;
    localparam int unsigned SW = vsd_pkg::SHIFT_W;

    // Decoder state
    logic [VW-1:0] acc_reg,    acc_next;
    logic [CW-1:0] seen_reg,   seen_next;
    logic          long_reg,   long_next;
    logic          signed_reg, signed_next;

    // Result register
    logic          out_valid_reg;
    logic [VW-1:0] value_reg,    value_next;
    logic [CW-1:0] count_reg,    count_next;
    logic          overlong_reg, overlong_next;

    logic          accept;
    logic          first_byte;
    logic          cont;
    logic          emit;
    logic [SW-1:0] shift_amt;
    logic [VW-1:0] payload_shifted;
    logic [VW-1:0] acc_raw;
    logic [CW-1:0] limit;
    logic [HW-1:0] short_zz;

    // Take a byte whenever the result register is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Accumulate one byte and decide whether the value is complete
    always_comb
    begin
        first_byte  = (seen_reg == '0);
        cont        = s_axis_tdata[vsd_pkg::BYTE_W-1];
        long_next   = first_byte ? s_axis_tuser[0] : long_reg;
        signed_next = first_byte ? s_axis_tuser[1] : signed_reg;

        shift_amt       = SW'(seen_reg) * SW'(7);
        payload_shifted = VW'(s_axis_tdata[vsd_pkg::PAYLOAD_W-1:0]) << shift_amt;
        acc_raw         = (first_byte ? '0 : acc_reg) | payload_shifted;
        if (!long_next)
        begin
            acc_raw[VW-1:HW] = '0;
        end

        seen_next = seen_reg + CW'(1);
        limit     = long_next ? vsd_pkg::LIMIT_LONG : vsd_pkg::LIMIT_SHORT;
        emit      = !cont || (seen_next >= limit);

        // Finish: zigzag decode in signed mode and extend to 64 bits
        short_zz = (acc_raw[HW-1:0] >> 1) ^ {HW{acc_raw[0]}};
        if (long_next)
        begin
            value_next = signed_next ? ((acc_raw >> 1) ^ {VW{acc_raw[0]}}) : acc_raw;
        end
        else
        begin
            value_next = signed_next ? {{(VW-HW){short_zz[HW-1]}}, short_zz}
                                     : {{(VW-HW){1'b0}}, acc_raw[HW-1:0]};
        end
        count_next    = seen_next;
        overlong_next = cont;

        acc_next = emit ? '0 : acc_raw;
        if (emit)
        begin
            seen_next = '0;
        end
    end

    // Advance the decoder state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            seen_reg   <= '0;
            long_reg   <= 1'b0;
            signed_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg    <= acc_next;
            seen_reg   <= seen_next;
            long_reg   <= long_next;
            signed_reg <= signed_next;
        end
    end

    // Hold the result until the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            value_reg    <= value_next;
            count_reg    <= count_next;
            overlong_reg <= overlong_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{vsd_pkg::OUT_PAD_W{1'b0}}, count_reg, value_reg};
    assign m_axis_tuser  = overlong_reg;

endmodule

`default_nettype wire

/* tb/sv/varint_stream_decoder_unit_tb.sv */
// Self-checking bench for varint_stream_decoder_unit: drives LEB128 byte streams in both widths
// and both sign modes, predicts each decoded value in the bench and scores every result word.
// Depends on vsd_pkg and the decoder RTL.

module varint_stream_decoder_unit_tb;

    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned MAX_SHOWN  = 10;
    localparam int unsigned BITS_SHORT = 35;
    localparam int unsigned BITS_LONG  = 70;
    localparam logic [7:0]  CONT_BIT   = 8'h80;

    typedef struct packed {
        logic [vsd_pkg::VALUE_W-1:0] value;
        logic [vsd_pkg::COUNT_W-1:0] byte_count;
        logic                        overlong;
    } varint_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [vsd_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [vsd_pkg::IN_TUSER_W-1:0]    s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [vsd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [vsd_pkg::OUT_TUSER_W-1:0]   m_axis_tuser;

    // Bench-side decoder state
    logic [63:0]  acc_bits = '0;
    logic [3:0]   bytes_taken = '0;
    logic         wide_latched = 1'b0;
    logic         zigzag_latched = 1'b0;

    varint_t      pending_values[$];
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  error_count = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  words_in = 0;
    int unsigned  values_out = 0;
    int unsigned  overlong_out = 0;

    varint_stream_decoder_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] long_mode, [1] signed_mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [63:0] value, [67:64] byte_count, [71:68] zero
        .m_axis_tuser  (m_axis_tuser)    // [0] overlong
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Apply the latched width and zigzag modes to the raw accumulated bits
    function automatic logic [63:0] finish_value(input logic [63:0] raw);
        logic [31:0] half;
        begin
            if (wide_latched)
                return zigzag_latched ? ((raw >> 1) ^ {64{raw[0]}}) : raw;
            half = raw[31:0];
            if (zigzag_latched)
            begin
                half = (half >> 1) ^ {32{half[0]}};
                return {{32{half[31]}}, half};
            end
            return {32'd0, half};
        end
    endfunction

    // Advance the bench decoder by one byte; flag a finished value when one falls out
    task automatic decode_byte(input logic [7:0] b, input logic lm, input logic sm,
                               output bit done, output varint_t res);
        int unsigned shift;
        int unsigned limit_bits;
        begin
            if (bytes_taken == 0)
            begin
                wide_latched   = lm;
                zigzag_latched = sm;
                acc_bits       = '0;
            end
            shift      = 7 * bytes_taken;
            limit_bits = wide_latched ? BITS_LONG : BITS_SHORT;
            if (shift < 64)
                acc_bits = acc_bits | ({57'd0, b[6:0]} << shift);
            if (!wide_latched)
                acc_bits[63:32] = '0;
            bytes_taken = bytes_taken + 4'd1;
            done = !b[7] || (7 * bytes_taken >= limit_bits);
            res  = '0;
            if (done)
            begin
                res.value      = finish_value(acc_bits);
                res.byte_count = bytes_taken;
                res.overlong   = b[7];
                acc_bits       = '0;
                bytes_taken    = '0;
            end
        end
    endtask

    // Predict on every accepted input word
    always @(posedge clk)
    begin
        bit      done;
        varint_t res;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            decode_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1], done, res);
            words_in++;
            if (done)
                pending_values.push_back(res);
        end
    end

    // Score every accepted result word against the oldest prediction
    always @(posedge clk)
    begin
        varint_t got;
        varint_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value      = m_axis_tdata[vsd_pkg::VALUE_W-1:0];
            got.byte_count = m_axis_tdata[vsd_pkg::VALUE_W +: vsd_pkg::COUNT_W];
            got.overlong   = m_axis_tuser[0];
            values_out++;
            if (got.overlong)
                overlong_out++;
            if (pending_values.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("unexpected result: value=%h count=%0d overlong=%b",
                             got.value, got.byte_count, got.overlong);
            end
            else
            begin
                want = pending_values.pop_front();
                if (got.value !== want.value || got.byte_count !== want.byte_count ||
                    got.overlong !== want.overlong)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("mismatch: expected value=%h count=%0d overlong=%b, got value=%h count=%0d overlong=%b",
                                 want.value, want.byte_count, want.overlong,
                                 got.value, got.byte_count, got.overlong);
                end
            end
        end
    end

    // Drive back-pressure on the result side
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("varint_stream_decoder_unit_tb: errors");
            $finish;
        end
    end

    // Offer one input word, with random gaps before it, and hold until it is taken
    task automatic send_word(input logic [7:0] b, input logic lm, input logic sm);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            s_axis_tuser  <= {sm, lm};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    // Hold the input quiet until every predicted value has come out
    task automatic hold_until_drained();
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (pending_values.size() != 0)
                @(posedge clk);
        end
    endtask

    // Send one value of a given length with random payload; mode bits vary after the first byte
    task automatic send_varint(input int unsigned nbytes, input logic lm, input logic sm,
                               input bit runover);
        logic [7:0] b;
        begin
            for (int unsigned i = 0; i < nbytes; i++)
            begin
                b = ($urandom_range(3) == 0) ? 8'h7f : 8'($urandom_range(127));
                if (i + 1 < nbytes || runover)
                    b = b | CONT_BIT;
                if (i == 0)
                    send_word(b, lm, sm);
                else
                    send_word(b, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_single_bytes();
        begin
            send_word(8'h00, 1'b0, 1'b0);
            send_word(8'h7f, 1'b0, 1'b1);
            send_word(8'h01, 1'b1, 1'b1);
            send_word(8'h7f, 1'b1, 1'b0);
        end
    endtask

    // 32-bit width: top bits of the fifth byte dropped, mode bits ignored mid-value, run-over
    task automatic test_short_width();
        begin
            send_word(8'hff, 1'b0, 1'b1);
            for (int i = 0; i < 3; i++)
                send_word(8'hff, 1'b1, 1'b0);
            send_word(8'h7f, 1'b1, 1'b0);
            for (int i = 0; i < 5; i++)
                send_word(8'h80, 1'b0, 1'b0);
        end
    endtask

    // 64-bit width: full ten-byte value with a clipped tenth byte, then a signed run-over
    task automatic test_long_width();
        begin
            for (int i = 0; i < 9; i++)
                send_word(8'hff, 1'b1, 1'b0);
            send_word(8'h7f, 1'b0, 1'b1);
            for (int i = 0; i < 10; i++)
                send_word(8'hff, 1'b1, 1'b1);
        end
    endtask

    // Mostly well-formed values of random width, sign and length, with some raw noise
    task automatic test_random_streams(input int unsigned target);
        int unsigned start_words;
        int unsigned limit;
        int unsigned nbytes;
        logic        lm;
        logic        sm;
        begin
            start_words = words_in;
            while (words_in - start_words < target)
            begin
                if ($urandom_range(99) < 80)
                begin
                    lm     = 1'($urandom_range(1));
                    sm     = 1'($urandom_range(1));
                    limit  = lm ? 10 : 5;
                    nbytes = ($urandom_range(3) == 0) ? limit : $urandom_range(limit, 1);
                    send_varint(nbytes, lm, sm, (nbytes == limit) && ($urandom_range(3) == 0));
                end
                else
                begin
                    repeat ($urandom_range(3, 1))
                        send_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes();
        test_short_width();
        test_long_width();
        hold_until_drained();

        // Phases of idling: none, sender gaps, receiver stalls, both
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_streams(105);
        hold_until_drained();
        send_idle_pct = 85; recv_stall_pct = 0;
        test_random_streams(105);
        hold_until_drained();
        send_idle_pct = 0;  recv_stall_pct = 85;
        test_random_streams(105);
        hold_until_drained();
        send_idle_pct = 35; recv_stall_pct = 35;
        test_random_streams(105);
        hold_until_drained();

        repeat (8) @(posedge clk);
        if (pending_values.size() != 0)
            error_count += pending_values.size();

        $display("covered %0d input words and %0d decoded values (%0d overlong), %0d errors",
                 words_in, values_out, overlong_out, error_count);
        $display("both widths, both sign modes, byte limits, and four idling phases");
        if (error_count == 0)
            $display("varint_stream_decoder_unit_tb: clean");
        else
            $display("varint_stream_decoder_unit_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/vsd_pkg.sv
rtl/varint_stream_decoder_unit.sv
tb/sv/varint_stream_decoder_unit_tb.sv
